@@ hdl/crs_pkg.sv @@
// ----------------------------------------------------------------------------
// crs_pkg
// shared types and constants for the catmull-rom spline sampler
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int COORD_W     = 16;                 // signed q12.4 coordinate
  localparam int COEF_W      = 20;                 // polynomial coefficients
  localparam int T_W         = 16;                 // q0.16 curve parameter
  localparam int N_W         = 7;                  // samples_per_segment width
  localparam int MAX_SAMPLES = 64;
  localparam int N_RESET     = 10;
  localparam int PROD_W      = COEF_W + T_W + 1;   // signed product
  localparam int ACC_W       = 40;                 // sample accumulator
  localparam int FRAC_SH     = 17;                 // q.16 weights times the factor of two
  localparam int RES_W       = ACC_W - FRAC_SH;
  localparam int DIV_MSB     = T_W;                // dividend 2^16 has its one at this bit
  localparam int DIV_CNT_W   = $clog2(DIV_MSB + 1);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // one segment to be sampled, per coordinate: p1, c1, c2, c3
  typedef struct packed {
    logic signed [COORD_W-1:0] p1_x;
    logic signed [COEF_W-1:0]  c1_x;
    logic signed [COEF_W-1:0]  c2_x;
    logic signed [COEF_W-1:0]  c3_x;
    logic signed [COORD_W-1:0] p1_y;
    logic signed [COEF_W-1:0]  c1_y;
    logic signed [COEF_W-1:0]  c2_y;
    logic signed [COEF_W-1:0]  c3_y;
    logic [N_W-1:0]            n;
  } crs_job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_MUL,
    B_EMIT
  } crs_back_state_e;

  // multiplier schedule for one sample
  typedef enum logic [3:0] {
    ST_TT,
    ST_T2T,
    ST_C1X,
    ST_C2X,
    ST_C3X,
    ST_C1Y,
    ST_C2Y,
    ST_C3Y,
    ST_ACC
  } crs_mul_step_e;

endpackage

@@ hdl/crs_front.sv @@
// ----------------------------------------------------------------------------
// crs_front
// point window, curve start handling and segment coefficient set-up
// ----------------------------------------------------------------------------
module crs_front import crs_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [N_W-1:0]            cfg_wdata_i,
  input  logic                      accept_i,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic                      start_curve_i,
  input  logic                      full_i,
  output logic                      push_o,
  output crs_job_t                  job_o
);

  logic [N_W-1:0]            n_cfg_q;
  logic [N_W-1:0]            n_eff;
  logic signed [COORD_W-1:0] win_x_q [3];
  logic signed [COORD_W-1:0] win_y_q [3];
  logic [1:0]                seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_cfg_q <= N_W'(N_RESET);
    end else if (cfg_we_i) begin
      n_cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (n_cfg_q == '0) begin
      n_eff = N_W'(1);
    end else if (n_cfg_q > N_W'(MAX_SAMPLES)) begin
      n_eff = N_W'(MAX_SAMPLES);
    end else begin
      n_eff = n_cfg_q;
    end
  end

  function automatic logic signed [COEF_W-1:0] ext(input logic signed [COORD_W-1:0] v);
    return COEF_W'(v);
  endfunction

  function automatic logic signed [COEF_W-1:0] coef2(input logic signed [COEF_W-1:0] p0,
      input logic signed [COEF_W-1:0] p1, input logic signed [COEF_W-1:0] p2,
      input logic signed [COEF_W-1:0] p3);
    return (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef3(input logic signed [COEF_W-1:0] p0,
      input logic signed [COEF_W-1:0] p1, input logic signed [COEF_W-1:0] p2,
      input logic signed [COEF_W-1:0] p3);
    logic signed [COEF_W-1:0] d;
    d = p1 - p2;
    return (p3 - p0) + (d <<< 1) + d;
  endfunction

  // a start flag empties the window, so such a point never completes a segment
  assign push_o = accept_i && !start_curve_i && (seen_q == 2'd3);

  always_comb begin
    job_o.p1_x = win_x_q[1];
    job_o.c1_x = ext(win_x_q[2]) - ext(win_x_q[0]);
    job_o.c2_x = coef2(ext(win_x_q[0]), ext(win_x_q[1]), ext(win_x_q[2]), ext(point_x_i));
    job_o.c3_x = coef3(ext(win_x_q[0]), ext(win_x_q[1]), ext(win_x_q[2]), ext(point_x_i));
    job_o.p1_y = win_y_q[1];
    job_o.c1_y = ext(win_y_q[2]) - ext(win_y_q[0]);
    job_o.c2_y = coef2(ext(win_y_q[0]), ext(win_y_q[1]), ext(win_y_q[2]), ext(point_y_i));
    job_o.c3_y = coef3(ext(win_y_q[0]), ext(win_y_q[1]), ext(win_y_q[2]), ext(point_y_i));
    job_o.n    = n_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      for (int i = 0; i < 3; i++) begin
        win_x_q[i] <= '0;
        win_y_q[i] <= '0;
      end
    end else if (accept_i) begin
      if (start_curve_i) begin
        win_x_q[0] <= '0;
        win_x_q[1] <= '0;
        win_y_q[0] <= '0;
        win_y_q[1] <= '0;
        seen_q     <= 2'd1;
      end else begin
        win_x_q[0] <= win_x_q[1];
        win_x_q[1] <= win_x_q[2];
        win_y_q[0] <= win_y_q[1];
        win_y_q[1] <= win_y_q[2];
        if (seen_q != 2'd3) begin
          seen_q <= seen_q + 2'd1;
        end
      end
      win_x_q[2] <= point_x_i;
      win_y_q[2] <= point_y_i;
    end
  end

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("segment pushed into a full queue");

  a_n_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (job_o.n != '0) && (job_o.n <= N_W'(MAX_SAMPLES)))
    else $error("segment sample count out of range");

  a_push_needs_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && start_curve_i) |=> (seen_q == 2'd1))
    else $error("window count not restarted on curve start");

endmodule

@@ hdl/crs_queue.sv @@
// ----------------------------------------------------------------------------
// crs_queue
// short segment queue between the point front end and the sampler
// ----------------------------------------------------------------------------
module crs_queue import crs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  crs_job_t job_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output crs_job_t job_o
);

  crs_job_t            entry_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = entry_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] inc_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= inc_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= inc_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue fill count beyond depth");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");

  a_push_moves_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |=> (wr_ptr_q != $past(wr_ptr_q)) || (QDEPTH == 1))
    else $error("write pointer did not advance");

endmodule

@@ hdl/crs_back.sv @@
// ----------------------------------------------------------------------------
// crs_back
// segment sampler: step divider, shared multiplier and output register
// ----------------------------------------------------------------------------
module crs_back import crs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  crs_job_t            job_i,
  output logic                pop_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [2*COORD_W-1:0] m_data_o,
  output logic                m_last_o
);

  crs_back_state_e state_q, state_d;
  crs_mul_step_e   step_q;

  crs_job_t                 job_q;
  logic [N_W-1:0]           j_q;
  logic [T_W:0]             t_q;
  logic [T_W:0]             q0_q;
  logic [N_W-1:0]           r_q;
  logic [N_W-1:0]           r0_q;
  logic [DIV_CNT_W-1:0]     div_cnt_q;
  logic [T_W-1:0]           t2_q;
  logic [T_W-1:0]           t3_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_x_q;
  logic signed [ACC_W-1:0]  acc_y_q;

  logic                     out_free;
  logic                     emit;
  logic                     is_last;

  logic signed [COEF_W-1:0] mul_a;
  logic [T_W-1:0]           mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ACC_W-1:0]  prod_ext;

  logic [N_W:0]             rem_sh;
  logic                     q_bit;
  logic [N_W:0]             r_sum;
  logic                     r_wrap;

  assign out_free = !m_valid_o || m_ready_i;
  assign is_last  = (j_q == job_q.n - N_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        if (div_cnt_q == '0) begin
          state_d = B_MUL;
        end
      end
      B_MUL: begin
        if (step_q == ST_ACC) begin
          state_d = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = is_last ? B_IDLE : B_MUL;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // one shared signed multiplier, operands chosen by the schedule step
  always_comb begin
    case (step_q)
      ST_TT:   begin mul_a = COEF_W'(t_q[T_W-1:0]);      mul_b = t_q[T_W-1:0]; end
      ST_T2T:  begin mul_a = COEF_W'(prod_q[2*T_W-1:T_W]); mul_b = t_q[T_W-1:0]; end
      ST_C1X:  begin mul_a = job_q.c1_x; mul_b = t_q[T_W-1:0]; end
      ST_C2X:  begin mul_a = job_q.c2_x; mul_b = t2_q; end
      ST_C3X:  begin mul_a = job_q.c3_x; mul_b = t3_q; end
      ST_C1Y:  begin mul_a = job_q.c1_y; mul_b = t_q[T_W-1:0]; end
      ST_C2Y:  begin mul_a = job_q.c2_y; mul_b = t2_q; end
      ST_C3Y:  begin mul_a = job_q.c3_y; mul_b = t3_q; end
      default: begin mul_a = '0;         mul_b = '0; end
    endcase
  end

  assign mul_p    = mul_a * $signed({1'b0, mul_b});
  assign prod_ext = ACC_W'(prod_q);

  // restoring division of 2^16 by n, one quotient bit a cycle
  assign rem_sh = {r0_q, (div_cnt_q == DIV_CNT_W'(DIV_MSB))};
  assign q_bit  = (rem_sh >= {1'b0, job_q.n});

  // t advances by the quotient, plus one whenever the remainder wraps
  assign r_sum  = {1'b0, r_q} + {1'b0, r0_q};
  assign r_wrap = (r_sum >= {1'b0, job_q.n});

  function automatic logic signed [ACC_W-1:0] p1_base(input logic signed [COORD_W-1:0] p);
    return ACC_W'(p) <<< FRAC_SH;
  endfunction

  function automatic logic [COORD_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sum;
    logic signed [RES_W-1:0] r;
    sum = acc + ACC_W'(1 <<< (FRAC_SH - 1));
    r   = sum[ACC_W-1:FRAC_SH];
    if (r > RES_W'((1 <<< (COORD_W - 1)) - 1)) begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end else if (r < -RES_W'(1 <<< (COORD_W - 1))) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return r[COORD_W-1:0];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q     <= job_i;
      j_q       <= '0;
      t_q       <= '0;
      r_q       <= '0;
      r0_q      <= '0;
      q0_q      <= '0;
      div_cnt_q <= DIV_CNT_W'(DIV_MSB);
    end
    if (state_q == B_DIV) begin
      r0_q      <= q_bit ? N_W'(rem_sh - {1'b0, job_q.n}) : N_W'(rem_sh);
      q0_q      <= {q0_q[T_W-1:0], q_bit};
      div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
    end
    if (state_q == B_MUL) begin
      prod_q <= mul_p;
      case (step_q)
        ST_T2T: t2_q    <= prod_q[2*T_W-1:T_W];
        ST_C1X: t3_q    <= prod_q[2*T_W-1:T_W];
        ST_C2X: acc_x_q <= p1_base(job_q.p1_x) + prod_ext;
        ST_C3X: acc_x_q <= acc_x_q + prod_ext;
        ST_C1Y: acc_x_q <= acc_x_q + prod_ext;
        ST_C2Y: acc_y_q <= p1_base(job_q.p1_y) + prod_ext;
        ST_C3Y: acc_y_q <= acc_y_q + prod_ext;
        ST_ACC: acc_y_q <= acc_y_q + prod_ext;
        default: ;
      endcase
    end
    if (emit) begin
      m_data_o <= {round_sat(acc_y_q), round_sat(acc_x_q)};
      m_last_o <= is_last;
      j_q      <= j_q + N_W'(1);
      t_q      <= t_q + q0_q + (T_W+1)'(r_wrap);
      r_q      <= r_wrap ? N_W'(r_sum - {1'b0, job_q.n}) : N_W'(r_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_TT;
    end else if (state_q == B_MUL) begin
      step_q <= (step_q == ST_ACC) ? ST_TT : crs_mul_step_e'(step_q + 4'd1);
    end else if (state_q == B_DIV) begin
      step_q <= ST_TT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_o <= 1'b0;
    end else if (emit) begin
      m_valid_o <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_o <= 1'b0;
    end
  end

  a_t_below_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_MUL) |-> !t_q[T_W])
    else $error("curve parameter reached one inside a run");

  a_rem_below_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_MUL || state_q == B_EMIT) |-> (r_q < job_q.n) && (r0_q < job_q.n))
    else $error("step remainder not below sample count");

  a_j_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_MUL || state_q == B_EMIT) |-> (j_q < job_q.n))
    else $error("sample index past end of run");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && is_last) |=> (state_q == B_IDLE))
    else $error("run continued after last sample");

endmodule

@@ hdl/catmull_rom_spline_sampler_core.sv @@
// ----------------------------------------------------------------------------
// catmull_rom_spline_sampler_core
// uniform catmull-rom sampler over a stream of 2d q12.4 control points
// ----------------------------------------------------------------------------
//  channel     | direction | payload
//  s_axis      | in        | tdata: point_x, point_y; tuser: start_curve
//  m_axis      | out       | tdata: sample_x, sample_y; tlast: last_of_run
//  cfg         | in        | wdata: samples_per_segment (write only)
//
//  a point that completes a segment is loaded from the queue and given a step
//  division, then each sample takes nine multiplier steps on the one shared
//  multiplier plus an emit, which waits while m_axis is stalled
//  points that only fill the window push nothing; two segments queue ahead
//  reset clears window, point count, queue and output valid; n resets to 10
//  a stalled m_axis holds the sampler, and s_axis stalls once the queue fills
// ----------------------------------------------------------------------------
module catmull_rom_spline_sampler_core import crs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [2*COORD_W-1:0] s_axis_tdata_i,   // point_x, point_y
  input  logic                 s_axis_tuser_i,   // start_curve
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [2*COORD_W-1:0] m_axis_tdata_o,   // sample_x, sample_y
  output logic                 m_axis_tlast_o,
  input  logic                 cfg_we_i,
  input  logic [N_W-1:0]       cfg_wdata_i
);

  logic     accept;
  logic     push;
  logic     full;
  logic     pop;
  logic     empty;
  crs_job_t job_in;
  crs_job_t job_out;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  crs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .point_x_i     (s_axis_tdata_i[COORD_W-1:0]),
    .point_y_i     (s_axis_tdata_i[2*COORD_W-1:COORD_W]),
    .start_curve_i (s_axis_tuser_i),
    .full_i        (full),
    .push_o        (push),
    .job_o         (job_in)
  );

  crs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_out)
  );

  crs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .job_i     (job_out),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o)
  );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the catmull-rom spline sampler core
// ----------------------------------------------------------------------------
// control points go in on s_axis with random gaps; every sample on m_axis is
// compared against a software copy of the sampler that tracks the point
// window and the sample count. directed points first, then random curves
// over several sample counts, one of them under a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import crs_pkg::*;

  localparam int STALL_LIMIT = 8000;   // cycles with no request moving
  localparam int HOLD_CYCLES = 1500;
  localparam int SETTLE_WAIT = 40;
  localparam int PHASE_ITEMS = 44;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } spline_sample_t;

  class SplinePredictor;
    logic [COORD_W-1:0] win_x[3];
    logic [COORD_W-1:0] win_y[3];
    int unsigned        filled;
    logic [N_W-1:0]     spacing;
    spline_sample_t     expected_q[$];
    int unsigned        errors;

    function new();
      foreach (win_x[i]) begin
        win_x[i] = '0;
        win_y[i] = '0;
      end
      filled  = 0;
      spacing = N_W'(N_RESET);
      errors  = 0;
    endfunction

    function void set_spacing(logic [N_W-1:0] v);
      spacing = v;
    endfunction

    // one coordinate of the hermite form, rounded half up and saturated
    function logic [COORD_W-1:0] blend(longint p0, longint p1, longint p2, longint p3,
                                       longint t, longint t2, longint t3);
      longint c1, c2, c3, acc, r;
      c1  = p2 - p0;
      c2  = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      c3  = -p0 + 3 * p1 - 3 * p2 + p3;
      acc = p1 * 131072 + c1 * t + c2 * t2 + c3 * t3 + 65536;
      r   = acc >>> 17;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return COORD_W'(r);
    endfunction

    function void note_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py, logic sc);
      longint n, tu, t2, t3;
      spline_sample_t s;
      if (sc) begin
        foreach (win_x[i]) begin
          win_x[i] = '0;
          win_y[i] = '0;
        end
        filled = 0;
      end
      if (filled >= 3) begin
        n = spacing;
        if (n == 0) n = 1;
        if (n > MAX_SAMPLES) n = MAX_SAMPLES;
        for (int j = 0; j < n; j++) begin
          tu  = (longint'(j) << 16) / n;
          t2  = (tu * tu) >> 16;
          t3  = (t2 * tu) >> 16;
          s.x = blend($signed(win_x[0]), $signed(win_x[1]), $signed(win_x[2]),
                      $signed(px), tu, t2, t3);
          s.y = blend($signed(win_y[0]), $signed(win_y[1]), $signed(win_y[2]),
                      $signed(py), tu, t2, t3);
          s.last = (j == n - 1);
          expected_q = {expected_q, s};
        end
      end
      win_x[0] = win_x[1];
      win_x[1] = win_x[2];
      win_x[2] = px;
      win_y[0] = win_y[1];
      win_y[1] = win_y[2];
      win_y[2] = py;
      if (filled < 3) filled++;
    endfunction

    function void check_sample(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy, logic last);
      spline_sample_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected sample, expected none, got x %0d y %0d last %0b",
                 $time, $signed(sx), $signed(sy), last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (sx !== e.x) begin
        $display("%0t: sample_x mismatch, expected %0d, got %0d",
                 $time, $signed(e.x), $signed(sx));
        errors++;
      end
      if (sy !== e.y) begin
        $display("%0t: sample_y mismatch, expected %0d, got %0d",
                 $time, $signed(e.y), $signed(sy));
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_of_run mismatch, expected %0b, got %0b", $time, e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_valid = 1'b0;
  logic [2*COORD_W-1:0] s_data = '0;
  logic                 s_user = 1'b0;
  logic                 m_ready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [N_W-1:0]       cfg_wdata = '0;
  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [2*COORD_W-1:0] m_axis_tdata_o;
  logic                 m_axis_tlast_o;

  bit quiet = 1'b0;      // no idling on either side
  bit hold_req = 1'b0;   // ask the receiver for a long hold-off
  int stall_cycles = 0;

  SplinePredictor sampler_model = new();

  catmull_rom_spline_sampler_core uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random back-pressure, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_ready <= quiet || ($urandom_range(99) >= 21);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid_o && m_ready)
      sampler_model.check_sample(m_axis_tdata_o[COORD_W-1:0],
                                 m_axis_tdata_o[2*COORD_W-1:COORD_W], m_axis_tlast_o);
  end

  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic offer_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                             input logic sc);
    while (!quiet && $urandom_range(99) < 21) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {py, px};
    s_user  <= sc;
    @(posedge clk);
    while (!s_axis_tready_o) @(posedge clk);
    sampler_model.note_point(px, py, sc);
  endtask

  // wait for every expected sample, then let window-only points finish
  task automatic settle();
    s_valid <= 1'b0;
    while (sampler_model.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_spacing(input logic [N_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sampler_model.set_spacing(v);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(15))
      0:             return 16'h7fff;
      1:             return 16'h8000;
      2, 3, 4, 5, 6: return 16'($urandom_range(4095)) - 16'd2048;
      default:       return 16'($urandom);
    endcase
  endfunction

  initial begin
    int plan[9];
    plan = '{1, 64, 2, 127, 5, 0, 33, 0, 0};
    plan[7] = $urandom_range(1, 64);
    plan[8] = $urandom_range(0, 127);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset count of ten; the first three points of a curve give nothing
    offer_point(16'd0, 16'd0, 1'b1);
    offer_point(16'd16, 16'd16, 1'b0);
    offer_point(16'd32, -16'sd16, 1'b0);
    offer_point(16'd48, 16'd0, 1'b0);
    // full-scale zigzag drives the overshoot into saturation
    offer_point(16'h7fff, 16'h8000, 1'b0);
    offer_point(16'h8000, 16'h7fff, 1'b0);
    offer_point(16'h7fff, 16'h8000, 1'b0);
    offer_point(16'h8000, 16'h7fff, 1'b0);
    offer_point(16'hffff, 16'h0000, 1'b0);
    // restart mid-curve, then again after only two points
    offer_point(16'd100, 16'd200, 1'b1);
    offer_point(-16'sd100, -16'sd200, 1'b0);
    offer_point(16'd1, 16'd1, 1'b1);
    offer_point(16'd2, 16'd2, 1'b0);
    offer_point(16'd3, 16'd3, 1'b0);
    offer_point(16'd4, 16'd4, 1'b0);
    settle();

    // a count of zero acts as one
    write_spacing(7'd0);
    offer_point(16'h7fff, 16'h7fff, 1'b0);
    offer_point(16'h8000, 16'h8000, 1'b0);
    offer_point(16'h1234, 16'hedcb, 1'b0);
    settle();

    // a count above the maximum is limited to it
    write_spacing(7'd127);
    offer_point(16'd0, 16'd0, 1'b1);
    offer_point(16'h0100, 16'hff00, 1'b0);
    offer_point(16'h0200, 16'h0100, 1'b0);
    offer_point(16'h0300, 16'h0000, 1'b0);
    offer_point(16'h8000, 16'h7fff, 1'b0);
    settle();

    for (int p = 0; p < 9; p++) begin
      write_spacing(N_W'(plan[p]));
      quiet = (p == 6);
      if (p == 4) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++)
        offer_point(rand_coord(), rand_coord(), (k == 0) || ($urandom_range(9) == 0));
      settle();
    end

    if (sampler_model.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
